### src/thop_pkg.sv
// thop_pkg: payload word types shared by the channel interfaces and the parser
`default_nettype none

package thop_pkg;

    // one byte of the received segment
    typedef struct packed {
        logic [7:0] seg_byte;
        logic       seg_start;
    } t_in_word;

    // decoded header fields of one segment
    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [3:0]  data_offset;
        logic [5:0]  reserved_bits;
        logic [5:0]  flag_bits;
        logic [15:0] window_size;
        logic [15:0] checksum_field;
        logic [15:0] urgent_ptr;
        logic [15:0] max_segment_size;
    } t_out_word;

endpackage

`default_nettype wire

### src/thop_if.sv
// thop_if: valid/ready channels for segment bytes and decoded headers
`default_nettype none

interface thop_in_if import thop_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thop_out_if import thop_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/tcp_header_option_parser.sv
// tcp_header_option_parser: byte-serial TCP header and MSS option decoder
//
//   channel | dir | word       | meaning
//   i_in    | in  | t_in_word  | one segment byte, seg_start on byte 0
//   o_out   | out | t_out_word | decoded header, one per segment
//
// One byte is taken every cycle while the result side keeps up.
// A byte passes an input register, then is decoded into the header
// store and the output register: a result is registered as the last
// header byte leaves the input register. A waiting result stalls
// the decode stage, and the input register then holds one more byte.
// Synchronous active-low reset returns to waiting for a start byte.
`default_nettype none

module tcp_header_option_parser import thop_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    thop_in_if.sink    i_in,
    thop_out_if.source o_out
);

    localparam logic [5:0] FIXED_LEN   = 6'd20;
    localparam logic [6:0] FIXED_LEN_W = 7'd20;
    localparam logic [7:0] OPT_END     = 8'h00;
    localparam logic [7:0] OPT_NOP     = 8'h01;
    localparam logic [7:0] OPT_MSS     = 8'h02;
    localparam logic [15:0] MSS_DEFAULT = 16'hFFFF;

    // option scan states
    localparam logic [1:0] PH_KIND = 2'd0;
    localparam logic [1:0] PH_MSS  = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    // input stage
    logic      r_in_valid;
    t_in_word  r_in_word;

    // parse state
    logic       r_in_header;
    logic [5:0] r_pos;
    logic [1:0] r_phase;
    logic [1:0] r_opt_cnt;
    logic [15:0] r_mss;
    logic [7:0] r_mss_high;
    logic [7:0] r_store [20];

    // output stage
    logic      r_out_valid;
    t_out_word r_out_word;

    // next values
    logic       proc_go;
    logic       in_take;
    logic       act;
    logic [5:0] pos;
    logic [6:0] pos_inc;
    logic [6:0] hlen;
    logic       last;
    logic [7:0] b;
    logic [1:0] n_phase;
    logic [1:0] n_opt_cnt;
    logic [15:0] n_mss;
    logic [7:0] n_mss_high;
    logic       n_in_header;
    logic [5:0] n_pos;
    logic [7:0] n_store [20];
    t_out_word  n_out_word;

    // handshakes
    assign proc_go     = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready  = ~r_in_valid | proc_go;
    assign in_take     = i_in.valid & i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // decode of the word in the input register
    always_comb begin
        b   = r_in_word.seg_byte;
        act = r_in_word.seg_start | r_in_header;
        pos = r_in_word.seg_start ? 6'd0 : r_pos;

        // a start byte restarts the option scan
        n_phase    = r_in_word.seg_start ? PH_KIND : r_phase;
        n_opt_cnt  = r_in_word.seg_start ? 2'd0 : r_opt_cnt;
        n_mss      = r_in_word.seg_start ? MSS_DEFAULT : r_mss;
        n_mss_high = r_mss_high;

        // fixed header bytes
        for (int i = 0; i < 20; i++) begin
            n_store[i] = (act && pos == 6'(i)) ? b : r_store[i];
        end

        // option scan past the fixed header
        if (act && pos >= FIXED_LEN) begin
            case (n_phase)
                PH_KIND: begin
                    if (b == OPT_MSS) begin
                        n_phase   = PH_MSS;
                        n_opt_cnt = 2'd1;
                    end else if (b != OPT_NOP) begin
                        // end of list and unknown kinds both stop
                        n_phase = (b == OPT_END) ? PH_STOP : PH_STOP;
                    end
                end
                PH_MSS: begin
                    case (n_opt_cnt)
                        2'd1: n_opt_cnt = 2'd2;
                        2'd2: begin
                            n_mss_high = b;
                            n_opt_cnt  = 2'd3;
                        end
                        2'd3: begin
                            n_mss     = {n_mss_high, b};
                            n_opt_cnt = 2'd0;
                            n_phase   = PH_KIND;
                        end
                        default: n_opt_cnt = n_opt_cnt;
                    endcase
                end
                default: n_phase = n_phase;
            endcase
        end

        // header length from data offset, at least the fixed part
        hlen = (n_store[12][7:4] < 4'd5) ? FIXED_LEN_W : {1'b0, n_store[12][7:4], 2'b00};
        pos_inc = {1'b0, pos} + 7'd1;
        last    = act && (pos_inc >= FIXED_LEN_W) && (pos_inc >= hlen);

        n_in_header = last ? 1'b0 : act;
        n_pos       = (last || !act) ? 6'd0 : pos_inc[5:0];

        // result fields
        n_out_word.src_port         = {n_store[0], n_store[1]};
        n_out_word.dst_port         = {n_store[2], n_store[3]};
        n_out_word.seq_num          = {n_store[4], n_store[5], n_store[6], n_store[7]};
        n_out_word.ack_num          = {n_store[8], n_store[9], n_store[10], n_store[11]};
        n_out_word.data_offset      = n_store[12][7:4];
        n_out_word.reserved_bits    = {n_store[12][3:0], n_store[13][7:6]};
        n_out_word.flag_bits        = n_store[13][5:0];
        n_out_word.window_size      = {n_store[14], n_store[15]};
        n_out_word.checksum_field   = {n_store[16], n_store[17]};
        n_out_word.urgent_ptr       = {n_store[18], n_store[19]};
        n_out_word.max_segment_size = n_mss;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in.data;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
            r_pos       <= 6'd0;
            r_phase     <= PH_KIND;
            r_opt_cnt   <= 2'd0;
            r_mss       <= MSS_DEFAULT;
        end else if (proc_go) begin
            r_in_header <= n_in_header;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_opt_cnt   <= n_opt_cnt;
            r_mss       <= n_mss;
        end
    end

    // header store and pending mss byte
    always_ff @(posedge i_clk) begin
        if (proc_go) begin
            r_mss_high <= n_mss_high;
            for (int i = 0; i < 20; i++) begin
                r_store[i] <= n_store[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= last;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && last) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire
